[hdl/jkve_pkg.sv]
`default_nettype none
package jkve_pkg;

   localparam int MAX_KEY_DEF  = 16;
   localparam int MAX_NEST_DEF = 255;
   localparam int NAME_W       = 128;
   localparam int REG_W        = 64;
   localparam int LEN_W        = 5;
   localparam int CAP_W        = 9;
   localparam int CSR_IDX_W    = 3;
   localparam int RSP_DATA_W   = 80;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd64;
   localparam logic [CAP_W-1:0] CAP_MAX   = 9'd256;

   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_LO  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_HI  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEC_LO  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEC_HI  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SEC_LEN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_KIND    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CAP     = 3'd7;

   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_MISSING  = 2'd1;
   localparam logic [1:0] ST_NO_DIGIT = 2'd2;

   typedef enum logic [8:0] {
      PH_SEEK   = 9'b000000001,
      PH_BRACE  = 9'b000000010,
      PH_BODY   = 9'b000000100,
      PH_COLON  = 9'b000001000,
      PH_WS     = 9'b000010000,
      PH_COPY   = 9'b000100000,
      PH_SIGN   = 9'b001000000,
      PH_DIGITS = 9'b010000000,
      PH_HOLD   = 9'b100000000
   } phase_type;

   function automatic logic is_ws4(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return is_ws4(c) || c == CH_COLON;
   endfunction

   function automatic logic is_space6(input logic [7:0] c);
      return is_ws4(c) || c == CH_VT || c == CH_FF;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

endpackage
`default_nettype wire

[hdl/jkve_match.sv]
`default_nettype none
module jkve_match #(
   parameter int MAX_KEY = jkve_pkg::MAX_KEY_DEF,
   parameter int WIN     = MAX_KEY + 3,
   parameter int LW      = $clog2(MAX_KEY + 1)
) (
   input  wire logic [WIN-1:0][7:0]            window,
   input  wire logic [jkve_pkg::NAME_W-1:0]    name,
   input  wire logic [LW-1:0]                  len,
   output logic                                hit
);
   localparam int IW = $clog2(WIN);
   localparam int EXT_W = jkve_pkg::NAME_W + 8 * MAX_KEY;

   logic [EXT_W-1:0] name_ext;
   logic [IW-1:0]    span;
   logic             chars_ok;

   assign name_ext = {{(8 * MAX_KEY){1'b0}}, name};
   assign span     = IW'(int'(len) + 2);

   always_comb begin
      logic [IW-1:0] pos;
      chars_ok = 1'b1;
      for (int i = 0; i < MAX_KEY; i++) begin
         pos = IW'(int'(len) + 1 - i);
         if (i < int'(len) && window[pos] != name_ext[8*i +: 8])
            chars_ok = 1'b0;
      end
   end

   assign hit = jkve_pkg::is_sep(window[0]) && window[1] == jkve_pkg::CH_QUOTE &&
                window[span] == jkve_pkg::CH_QUOTE && chars_ok;
endmodule
`default_nettype wire

[hdl/json_key_value_extractor_unit.sv]
`default_nettype none
// A result beat is registered: it appears in the cycle after the text beat that causes it.
// Throughput: one text byte per cycle; the only stall is a result beat that is
// not taken, held in the single output register.
// Reset: synchronous, active high; clears the scan state, the result valid
// flag and the configuration (capacity back to 64, all else zero). Scan state also
// clears after every beat marked last.
module json_key_value_extractor_unit #(
   parameter int MAX_KEY  = jkve_pkg::MAX_KEY_DEF,
   parameter int MAX_NEST = jkve_pkg::MAX_NEST_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [7:0]                          req_tdata,  // text_byte
   input  wire logic                                req_tlast,  // end_of_text
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // value_byte [7:0], int_value [71:8], status [73:72], zero pad [79:74]
   output logic [jkve_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_tuser,  // byte_valid
   output logic                                     rsp_tlast,  // done_res
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [jkve_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [jkve_pkg::REG_W-1:0]          csr_data
);
   localparam int WIN = MAX_KEY + 3;
   localparam int IW  = $clog2(WIN);
   localparam int LW  = $clog2(MAX_KEY + 1);
   localparam int DW  = $clog2(MAX_NEST + 1);
   localparam int CW  = jkve_pkg::CAP_W;
   localparam logic [63:0] LIMIT   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SAT_LO  = 64'd922337203685477580;
   localparam logic [63:0] SAT_D9  = 64'd922337203685477579;

   // configuration
   logic [63:0]    key_lo_ff, key_hi_ff, sec_lo_ff, sec_hi_ff;
   logic [4:0]     key_len_ff, sec_len_ff;
   logic           kind_ff;
   logic [CW-1:0]  cap_ff;

   // scan state
   logic [WIN-1:0][7:0] win_ff, win_in;
   logic [WIN-1:0]      starts_ff, starts_in;
   jkve_pkg::phase_type ph_ff, ph_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic                inlit_ff, inlit_in, esc_ff, esc_in, neg_ff, neg_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [63:0]         acc_ff, acc_in;

   // result register
   logic          ov_ff;
   logic          obv_ff, ofin_ff;
   logic [7:0]    obyte_ff;
   logic [63:0]   oival_ff;
   logic [1:0]    ost_ff;

   logic          accept, emit, fin;
   logic [7:0]    b, vbyte;
   logic [63:0]   ival;
   logic [1:0]    status;
   logic [LW-1:0] klen, slen;
   logic [IW-1:0] kspan;
   logic [CW-1:0] cap;
   logic          key_hit, sec_hit;

   function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [3:0] d);
      logic [63:0] bound;
      bound = (d == 4'd9) ? SAT_D9 : SAT_LO;
      if (acc > bound) return LIMIT;
      return (acc << 3) + (acc << 1) + {60'd0, d};
   endfunction

   function automatic logic [63:0] int_result(input logic [63:0] acc, input logic neg);
      if (neg) return 64'd0 - acc;
      return (acc > I64_MAX) ? I64_MAX : acc;
   endfunction

   assign b          = req_tdata;
   assign req_tready = !ov_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign klen  = (int'(key_len_ff) > MAX_KEY) ? LW'(MAX_KEY) : LW'(key_len_ff);
   assign slen  = (int'(sec_len_ff) > MAX_KEY) ? LW'(MAX_KEY) : LW'(sec_len_ff);
   assign kspan = IW'(int'(klen) + 2);
   assign cap   = (cap_ff == '0) ? CW'(1) : (cap_ff > jkve_pkg::CAP_MAX) ?
                  jkve_pkg::CAP_MAX : cap_ff;

   assign win_in = {win_ff[WIN-2:0], b};

   jkve_match #(.MAX_KEY(MAX_KEY), .WIN(WIN), .LW(LW)) u_key_match (
      .window (win_in),
      .name   ({key_hi_ff, key_lo_ff}),
      .len    (klen),
      .hit    (key_hit)
   );

   jkve_match #(.MAX_KEY(MAX_KEY), .WIN(WIN), .LW(LW)) u_sec_match (
      .window (win_in),
      .name   ({sec_hi_ff, sec_lo_ff}),
      .len    (slen),
      .hit    (sec_hit)
   );

   always_comb begin
      logic [CW-1:0] cnt_next;
      ph_in     = ph_ff;
      depth_in  = depth_ff;
      inlit_in  = inlit_ff;
      esc_in    = esc_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      starts_in = {starts_ff[WIN-2:0], 1'b0};
      emit      = 1'b0;
      fin       = 1'b0;
      status    = jkve_pkg::ST_FOUND;
      vbyte     = 8'd0;
      ival      = 64'd0;
      cnt_next  = cnt_ff + CW'(1);
      case (ph_ff)
         jkve_pkg::PH_SEEK: begin
            if (sec_len_ff != 5'd0) begin
               if (sec_hit) ph_in = jkve_pkg::PH_BRACE;
            end else if (key_hit) begin
               ph_in = (b == jkve_pkg::CH_COLON) ? jkve_pkg::PH_WS : jkve_pkg::PH_COLON;
            end
         end
         jkve_pkg::PH_BRACE: begin
            if (b == jkve_pkg::CH_LBRACE) begin
               ph_in     = jkve_pkg::PH_BODY;
               depth_in  = DW'(1);
               inlit_in  = 1'b0;
               esc_in    = 1'b0;
               starts_in = '0;
            end
         end
         jkve_pkg::PH_BODY: begin
            if (!inlit_ff && b == jkve_pkg::CH_QUOTE) starts_in[0] = 1'b1;
            if (starts_in[kspan] && key_hit) begin
               ph_in = (b == jkve_pkg::CH_COLON) ? jkve_pkg::PH_WS : jkve_pkg::PH_COLON;
            end else if (inlit_ff) begin
               if (esc_ff) esc_in = 1'b0;
               else if (b == jkve_pkg::CH_BSLASH) esc_in = 1'b1;
               else if (b == jkve_pkg::CH_QUOTE) inlit_in = 1'b0;
            end else if (b == jkve_pkg::CH_QUOTE) begin
               inlit_in = 1'b1;
            end else if (b == jkve_pkg::CH_LBRACE) begin
               if (int'(depth_ff) < MAX_NEST) depth_in = depth_ff + DW'(1);
            end else if (b == jkve_pkg::CH_RBRACE) begin
               depth_in = depth_ff - DW'(1);
               if (depth_ff == DW'(1)) begin
                  fin    = 1'b1;
                  status = jkve_pkg::ST_MISSING;
               end
            end
         end
         jkve_pkg::PH_COLON: begin
            if (b == jkve_pkg::CH_COLON) ph_in = jkve_pkg::PH_WS;
         end
         jkve_pkg::PH_WS: begin
            if (!kind_ff) begin
               if (!jkve_pkg::is_ws4(b)) begin
                  if (b == jkve_pkg::CH_QUOTE) begin
                     if (cap <= CW'(1)) fin = 1'b1;
                     else begin
                        ph_in  = jkve_pkg::PH_COPY;
                        cnt_in = '0;
                     end
                  end else begin
                     fin    = 1'b1;
                     status = jkve_pkg::ST_MISSING;
                  end
               end
            end else if (!jkve_pkg::is_space6(b)) begin
               if (b == jkve_pkg::CH_PLUS || b == jkve_pkg::CH_MINUS) begin
                  neg_in = (b == jkve_pkg::CH_MINUS);
                  ph_in  = jkve_pkg::PH_SIGN;
               end else if (jkve_pkg::is_digit(b)) begin
                  acc_in = add_digit(64'd0, b[3:0]);
                  ph_in  = jkve_pkg::PH_DIGITS;
               end else begin
                  fin    = 1'b1;
                  status = jkve_pkg::ST_NO_DIGIT;
               end
            end
         end
         jkve_pkg::PH_COPY: begin
            if (b == jkve_pkg::CH_QUOTE) fin = 1'b1;
            else begin
               emit   = 1'b1;
               vbyte  = b;
               cnt_in = cnt_next;
               if ({1'b0, cnt_next} + (CW+1)'(1) >= {1'b0, cap}) fin = 1'b1;
            end
         end
         jkve_pkg::PH_SIGN: begin
            if (jkve_pkg::is_digit(b)) begin
               acc_in = add_digit(acc_ff, b[3:0]);
               ph_in  = jkve_pkg::PH_DIGITS;
            end else begin
               fin    = 1'b1;
               status = jkve_pkg::ST_NO_DIGIT;
            end
         end
         jkve_pkg::PH_DIGITS: begin
            if (jkve_pkg::is_digit(b)) acc_in = add_digit(acc_ff, b[3:0]);
            else begin
               fin  = 1'b1;
               ival = int_result(acc_ff, neg_ff);
            end
         end
         default: ph_in = jkve_pkg::PH_HOLD;
      endcase

      // end of text closes whatever is still open
      if (!fin && req_tlast && ph_in != jkve_pkg::PH_HOLD) begin
         fin = 1'b1;
         case (ph_in)
            jkve_pkg::PH_WS:
               status = kind_ff ? jkve_pkg::ST_NO_DIGIT : jkve_pkg::ST_MISSING;
            jkve_pkg::PH_COPY:   status = jkve_pkg::ST_FOUND;
            jkve_pkg::PH_SIGN:   status = jkve_pkg::ST_NO_DIGIT;
            jkve_pkg::PH_DIGITS: begin
               status = jkve_pkg::ST_FOUND;
               ival   = int_result(acc_in, neg_in);
            end
            default: status = jkve_pkg::ST_MISSING;
         endcase
      end
      if (fin) ph_in = jkve_pkg::PH_HOLD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_lo_ff  <= '0;
         key_hi_ff  <= '0;
         key_len_ff <= '0;
         sec_lo_ff  <= '0;
         sec_hi_ff  <= '0;
         sec_len_ff <= '0;
         kind_ff    <= 1'b0;
         cap_ff     <= jkve_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            jkve_pkg::REG_KEY_LO:  key_lo_ff  <= csr_data;
            jkve_pkg::REG_KEY_HI:  key_hi_ff  <= csr_data;
            jkve_pkg::REG_KEY_LEN: key_len_ff <= csr_data[4:0];
            jkve_pkg::REG_SEC_LO:  sec_lo_ff  <= csr_data;
            jkve_pkg::REG_SEC_HI:  sec_hi_ff  <= csr_data;
            jkve_pkg::REG_SEC_LEN: sec_len_ff <= csr_data[4:0];
            jkve_pkg::REG_KIND:    kind_ff    <= csr_data[0];
            jkve_pkg::REG_CAP:     cap_ff     <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         win_ff    <= '0;
         starts_ff <= '0;
         ph_ff     <= jkve_pkg::PH_SEEK;
         depth_ff  <= '0;
         inlit_ff  <= 1'b0;
         esc_ff    <= 1'b0;
         neg_ff    <= 1'b0;
         cnt_ff    <= '0;
         acc_ff    <= '0;
      end else if (accept) begin
         win_ff    <= win_in;
         starts_ff <= starts_in;
         ph_ff     <= ph_in;
         depth_ff  <= depth_in;
         inlit_ff  <= inlit_in;
         esc_ff    <= esc_in;
         neg_ff    <= neg_in;
         cnt_ff    <= cnt_in;
         acc_ff    <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (accept && (emit || fin)) ov_ff <= 1'b1;
      else if (rsp_tready) ov_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept && (emit || fin)) begin
         obv_ff   <= emit;
         obyte_ff <= vbyte;
         oival_ff <= ival;
         ost_ff   <= status;
         ofin_ff  <= fin;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = obv_ff;
   assign rsp_tlast  = ofin_ff;
   assign rsp_tdata  = {6'd0, ost_ff, oival_ff, obyte_ff};

   a_free_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   a_char_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[73:72] == jkve_pkg::ST_FOUND)
      else $error("string byte carries nonzero status");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> ph_ff == jkve_pkg::PH_SEEK && depth_ff == '0)
      else $error("scan state not cleared after last beat");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      int'(depth_ff) <= MAX_NEST)
      else $error("brace depth beyond nesting limit");
endmodule
`default_nettype wire

[dv/json_key_value_extractor_unit_checker.sv]
`default_nettype none
module json_key_value_extractor_unit_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [jkve_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            rsp_tuser,
   input  wire logic                            rsp_tlast,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [jkve_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [jkve_pkg::REG_W-1:0]      csr_data,
   output int                                   fail_count,
   output int                                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN = jkve_pkg::MAX_KEY_DEF + 3;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  value_byte;
      logic [63:0] int_value;
      logic [1:0]  status;
      logic        done;
   } extract_result_type;

   extract_result_type value_queue[$];

   logic [63:0]    key_lo, key_hi, sec_lo, sec_hi;
   logic [4:0]     key_len, sec_len;
   logic           kind_int;
   logic [8:0]     cap_reg;

   logic [7:0]          window [0:WIN-1];
   jkve_pkg::phase_type phase;
   int unsigned         depth;
   logic                in_lit, esc, neg;
   logic [63:0]         lit_marks;
   int unsigned         copied;
   logic [63:0]         accum;

   function automatic logic [7:0] name_at(logic [63:0] lo, logic [63:0] hi, int i);
      if (i < 8) return lo[8*i +: 8];
      if (i < 16) return hi[8*(i-8) +: 8];
      return 8'h00;
   endfunction

   function automatic int clamp(logic [4:0] len);
      return (len > jkve_pkg::MAX_KEY_DEF) ? jkve_pkg::MAX_KEY_DEF : int'(len);
   endfunction

   function automatic logic digit_char(logic [7:0] c);
      return c >= jkve_pkg::CH_ZERO && c <= jkve_pkg::CH_NINE;
   endfunction

   function automatic logic name_match(logic [63:0] lo, logic [63:0] hi, int len);
      int span;
      span = len + 2;
      if (!jkve_pkg::is_sep(window[0])) return 1'b0;
      if (window[1] != jkve_pkg::CH_QUOTE || window[span] != jkve_pkg::CH_QUOTE)
         return 1'b0;
      for (int i = 0; i < len; i++)
         if (window[span-1-i] != name_at(lo, hi, i)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [63:0] signed_value();
      if (neg) return 64'd0 - accum;
      return (accum > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : accum;
   endfunction

   task automatic clear_scan();
      for (int i = 0; i < WIN; i++) window[i] = 8'h00;
      phase = jkve_pkg::PH_SEEK;
      depth = 0;
      in_lit = 0;
      esc = 0;
      neg = 0;
      lit_marks = '0;
      copied = 0;
      accum = '0;
   endtask

   task automatic add_digit(logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - jkve_pkg::CH_ZERO);
      if (accum > (64'h8000_0000_0000_0000 - d) / 10) accum = 64'h8000_0000_0000_0000;
      else accum = accum * 10 + d;
   endtask

   task automatic scan_byte(logic [7:0] b, logic last);
      logic               emit, fin;
      logic [1:0]         st;
      logic [7:0]         vb;
      logic [63:0]        iv;
      int unsigned        cap;
      int                 klen;
      extract_result_type r;
      emit = 0; fin = 0; st = jkve_pkg::ST_FOUND; vb = 0; iv = 0;
      cap = cap_reg;
      klen = clamp(key_len);
      if (cap == 0) cap = 1;
      if (cap > 256) cap = 256;
      for (int i = WIN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      lit_marks = lit_marks << 1;

      case (phase)
         jkve_pkg::PH_SEEK: begin
            if (sec_len != 0) begin
               if (name_match(sec_lo, sec_hi, clamp(sec_len))) phase = jkve_pkg::PH_BRACE;
            end else if (name_match(key_lo, key_hi, klen)) begin
               phase = (b == jkve_pkg::CH_COLON) ? jkve_pkg::PH_WS : jkve_pkg::PH_COLON;
            end
         end
         jkve_pkg::PH_BRACE: begin
            if (b == jkve_pkg::CH_LBRACE) begin
               phase = jkve_pkg::PH_BODY;
               depth = 1;
               in_lit = 0;
               esc = 0;
               lit_marks = '0;
            end
         end
         jkve_pkg::PH_BODY: begin
            if (!in_lit && b == jkve_pkg::CH_QUOTE) lit_marks[0] = 1'b1;
            // key counts only when its opening quote started a literal
            if (lit_marks[klen+2] && name_match(key_lo, key_hi, klen)) begin
               phase = (b == jkve_pkg::CH_COLON) ? jkve_pkg::PH_WS : jkve_pkg::PH_COLON;
            end else if (in_lit) begin
               if (esc) esc = 0;
               else if (b == jkve_pkg::CH_BSLASH) esc = 1;
               else if (b == jkve_pkg::CH_QUOTE) in_lit = 0;
            end else if (b == jkve_pkg::CH_QUOTE) begin
               in_lit = 1;
            end else if (b == jkve_pkg::CH_LBRACE) begin
               if (depth < jkve_pkg::MAX_NEST_DEF) depth++;
            end else if (b == jkve_pkg::CH_RBRACE) begin
               depth--;
               if (depth == 0) begin
                  fin = 1;
                  st = jkve_pkg::ST_MISSING;
               end
            end
         end
         jkve_pkg::PH_COLON: if (b == jkve_pkg::CH_COLON) phase = jkve_pkg::PH_WS;
         jkve_pkg::PH_WS: begin
            if (!kind_int) begin
               if (!jkve_pkg::is_ws4(b)) begin
                  if (b == jkve_pkg::CH_QUOTE) begin
                     if (cap <= 1) fin = 1;
                     else begin
                        phase = jkve_pkg::PH_COPY;
                        copied = 0;
                     end
                  end else begin
                     fin = 1;
                     st = jkve_pkg::ST_MISSING;
                  end
               end
            end else if (!jkve_pkg::is_space6(b)) begin
               if (b == jkve_pkg::CH_PLUS || b == jkve_pkg::CH_MINUS) begin
                  neg = (b == jkve_pkg::CH_MINUS);
                  phase = jkve_pkg::PH_SIGN;
               end else if (digit_char(b)) begin
                  accum = 0;
                  add_digit(b);
                  phase = jkve_pkg::PH_DIGITS;
               end else begin
                  fin = 1;
                  st = jkve_pkg::ST_NO_DIGIT;
               end
            end
         end
         jkve_pkg::PH_COPY: begin
            if (b == jkve_pkg::CH_QUOTE) fin = 1;
            else begin
               emit = 1;
               vb = b;
               copied++;
               if (copied + 1 >= cap) fin = 1;
            end
         end
         jkve_pkg::PH_SIGN: begin
            if (digit_char(b)) begin
               add_digit(b);
               phase = jkve_pkg::PH_DIGITS;
            end else begin
               fin = 1;
               st = jkve_pkg::ST_NO_DIGIT;
            end
         end
         jkve_pkg::PH_DIGITS: begin
            if (digit_char(b)) add_digit(b);
            else begin
               fin = 1;
               iv = signed_value();
            end
         end
         default: phase = jkve_pkg::PH_HOLD;
      endcase

      if (!fin && last && phase != jkve_pkg::PH_HOLD) begin
         fin = 1;
         case (phase)
            jkve_pkg::PH_WS:
               st = kind_int ? jkve_pkg::ST_NO_DIGIT : jkve_pkg::ST_MISSING;
            jkve_pkg::PH_COPY:   st = jkve_pkg::ST_FOUND;
            jkve_pkg::PH_SIGN:   st = jkve_pkg::ST_NO_DIGIT;
            jkve_pkg::PH_DIGITS: begin
               st = jkve_pkg::ST_FOUND;
               iv = signed_value();
            end
            default:   st = jkve_pkg::ST_MISSING;
         endcase
      end
      if (fin) phase = jkve_pkg::PH_HOLD;
      if (last) clear_scan();
      if (emit || fin) begin
         r.byte_valid = emit;
         r.value_byte = vb;
         r.int_value  = iv;
         r.status     = st;
         r.done       = fin;
         value_queue.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      extract_result_type want, got;
      if (reset) begin
         key_lo = 0; key_hi = 0; key_len = 0;
         sec_lo = 0; sec_hi = 0; sec_len = 0;
         kind_int = 0; cap_reg = jkve_pkg::CAP_RESET;
         clear_scan();
         value_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.byte_valid = rsp_tuser;
            got.value_byte = rsp_tdata[7:0];
            got.int_value  = rsp_tdata[71:8];
            got.status     = rsp_tdata[73:72];
            got.done       = rsp_tlast;
            if (value_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %p", got);
               fail_count++;
            end else begin
               want = value_queue.pop_front();
               if (want != got) begin
                  if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               jkve_pkg::REG_KEY_LO:  key_lo = csr_data;
               jkve_pkg::REG_KEY_HI:  key_hi = csr_data;
               jkve_pkg::REG_KEY_LEN: key_len = csr_data[4:0];
               jkve_pkg::REG_SEC_LO:  sec_lo = csr_data;
               jkve_pkg::REG_SEC_HI:  sec_hi = csr_data;
               jkve_pkg::REG_SEC_LEN: sec_len = csr_data[4:0];
               jkve_pkg::REG_KIND:    kind_int = csr_data[0];
               jkve_pkg::REG_CAP:     cap_reg = csr_data[8:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
      end
      pending = value_queue.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule
`default_nettype wire

[dv/json_key_value_extractor_unit_tb.sv]
`default_nettype none
module json_key_value_extractor_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            req_tvalid = 0, req_tready;
   logic [7:0]                      req_tdata = 0;
   logic                            req_tlast = 0;
   logic                            rsp_tvalid, rsp_tready = 0;
   logic [jkve_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser, rsp_tlast;
   logic                            csr_valid = 0, csr_ready;
   logic [jkve_pkg::CSR_IDX_W-1:0]  csr_index = 0;
   logic [jkve_pkg::REG_W-1:0]      csr_data = 0;
   int                              fail_count, pending;

   int                    send_idle_pct = 0, stall_pct = 0;
   logic                  holding = 0;
   event                  begin_hold;
   int                    cycles = 0;

   logic [7:0]            key_chars[16], sec_chars[16];
   int                    key_n, sec_n;
   logic                  int_mode;
   logic [7:0]            doc[$];

   json_key_value_extractor_unit dut (.*);

   json_key_value_extractor_unit_checker scoreboard (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("json_key_value_extractor_unit_tb failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= !holding && ($urandom_range(99) >= stall_pct);

   initial forever begin
      @(begin_hold);
      holding <= 1;
      repeat (600) @(posedge clock);
      holding <= 0;
   end

   task automatic write_reg(logic [jkve_pkg::CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock iff csr_ready);
   endtask

   task automatic set_mode(int m);
      case (m % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 48; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 48; end
         default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
   endtask

   // drop the request, then wait for every expected result
   task automatic drain();
      req_tvalid <= 0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // key and section text come as strings; raw lengths may exceed 16
   task automatic configure(string key, int klen, string sec, int slen,
                            logic kind, logic [8:0] cap);
      logic [63:0] k0, k1, s0, s1;
      k0 = 0; k1 = 0; s0 = 0; s1 = 0;
      drain();
      foreach (key_chars[i]) begin
         key_chars[i] = (i < key.len()) ? key[i] : 8'h00;
         sec_chars[i] = (i < sec.len()) ? sec[i] : 8'h00;
         if (i < 8) begin
            k0[8*i +: 8] = key_chars[i];
            s0[8*i +: 8] = sec_chars[i];
         end else begin
            k1[8*(i-8) +: 8] = key_chars[i];
            s1[8*(i-8) +: 8] = sec_chars[i];
         end
      end
      key_n = (klen > 16) ? 16 : klen;
      sec_n = (slen > 16) ? 16 : slen;
      int_mode = kind;
      write_reg(jkve_pkg::REG_KEY_LO, k0);
      write_reg(jkve_pkg::REG_KEY_HI, k1);
      write_reg(jkve_pkg::REG_KEY_LEN, 64'(klen));
      write_reg(jkve_pkg::REG_SEC_LO, s0);
      write_reg(jkve_pkg::REG_SEC_HI, s1);
      write_reg(jkve_pkg::REG_SEC_LEN, 64'(slen));
      write_reg(jkve_pkg::REG_KIND, 64'(kind));
      write_reg(jkve_pkg::REG_CAP, 64'(cap));
      csr_valid <= 0;
   endtask

   task automatic put(string s);
      foreach (s[i]) doc.push_back(s[i]);
   endtask

   // valid stays up after the last beat so the next document can follow at once
   task automatic send_doc();
      for (int i = 0; i < doc.size(); i++) begin
         if ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         req_tvalid <= 1;
         req_tdata  <= doc[i];
         req_tlast  <= (i == doc.size() - 1);
         @(posedge clock iff req_tready);
      end
      doc.delete();
   endtask

   task automatic send_text(string s);
      put(s);
      send_doc();
   endtask

   task automatic put_quoted_name(logic [7:0] chars[16], int n);
      doc.push_back(jkve_pkg::CH_QUOTE);
      for (int i = 0; i < n; i++) doc.push_back(chars[i]);
      doc.push_back(jkve_pkg::CH_QUOTE);
   endtask

   task automatic put_ws();
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(5))
            0: doc.push_back(jkve_pkg::CH_TAB);
            1: doc.push_back(jkve_pkg::CH_LF);
            2: doc.push_back(jkve_pkg::CH_CR);
            3: doc.push_back(int_mode ? jkve_pkg::CH_VT : jkve_pkg::CH_SPACE);
            default: doc.push_back(jkve_pkg::CH_SPACE);
         endcase
      end
   endtask

   task automatic put_noise(int n);
      repeat (n) begin
         case ($urandom_range(7))
            0: doc.push_back(jkve_pkg::CH_QUOTE);
            1: doc.push_back(jkve_pkg::CH_COLON);
            2: doc.push_back(jkve_pkg::CH_LBRACE);
            3: doc.push_back(jkve_pkg::CH_RBRACE);
            4: doc.push_back(jkve_pkg::CH_BSLASH);
            default: doc.push_back(8'($urandom_range(255)));
         endcase
      end
   endtask

   task automatic put_value();
      int n;
      if (!int_mode) begin
         doc.push_back(($urandom_range(9) == 0) ? 8'h61 : jkve_pkg::CH_QUOTE);
         n = ($urandom_range(15) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 12);
         repeat (n) begin
            doc.push_back(8'($urandom_range(255)));
            if (doc[$] == jkve_pkg::CH_QUOTE) doc[$] = 8'h00;
         end
         doc.push_back(jkve_pkg::CH_QUOTE);
      end else begin
         case ($urandom_range(5))
            0: doc.push_back(jkve_pkg::CH_MINUS);
            1: doc.push_back(jkve_pkg::CH_PLUS);
            default: ;
         endcase
         n = ($urandom_range(7) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 6);
         repeat (n) doc.push_back(8'($urandom_range(jkve_pkg::CH_ZERO, jkve_pkg::CH_NINE)));
         doc.push_back(($urandom_range(1)) ? CH_COMMA : jkve_pkg::CH_RBRACE);
      end
   endtask

   task automatic build_doc();
      if ($urandom_range(9) < 8) begin
         put("{");
         if ($urandom_range(1)) put("\"a\\\"b\":\"x{\",");
         if (sec_n != 0) begin
            put_quoted_name(sec_chars, sec_n);
            put_ws();
            put(":");
            put_ws();
            put("{");
            if ($urandom_range(1)) put("\"p\":{\"q\":1},");
            if ($urandom_range(3) == 0) begin
               // key text hidden inside a literal must not match
               put("\"z\":\"\\\"");
               put_quoted_name(key_chars, key_n);
               put(":\",");
            end
            if ($urandom_range(7) == 0) put("}");
         end
         put_quoted_name(key_chars, key_n);
         put_ws();
         if ($urandom_range(7) == 0) put("x");
         put(":");
         put_ws();
         put_value();
         put("}}");
         if ($urandom_range(5) == 0) put_noise($urandom_range(1, 4));
         if ($urandom_range(6) == 0) repeat ($urandom_range(1, doc.size() - 1)) void'(doc.pop_back());
      end else begin
         put_noise($urandom_range(1, 30));
      end
   endtask

   function automatic string rand_name(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++)
         s = {s, string'(($urandom_range(9) == 0) ? 8'($urandom_range(1, 255))
                                                 : 8'($urandom_range(8'h61, 8'h64)))};
      return s;
   endfunction

   initial begin
      int          bytes;
      int          klen, slen;
      logic [8:0]  cap;
      logic [8:0]  caps[8] = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd64, 9'd256, 9'd300, 9'd511};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      configure("name", 4, "", 0, 0, 9'd64);
      send_text("{\"name\": \"abc\"}");
      send_text("{\"name\":\"x");
      send_text("{\"nam\":1}");
      put("{\"name\"\t:\r\n\"a");
      doc.push_back(8'h00);
      send_text("b\"}");
      send_text("{\"name\": 5}");

      configure("name", 4, "", 0, 1, 9'd64);
      send_text("{\"name\":+123,");
      send_text("{\"name\": -9223372036854775809}");
      send_text("{\"name\":99999999999999999999}");
      send_text("{\"name\": \v\f-x");
      send_text("{\"name\":-");
      send_text("{\"name\" : 42");

      configure("k", 1, "", 0, 0, 9'd1);
      send_text("\"k\":\"zz\"");
      configure("k", 1, "", 0, 0, 9'd3);
      send_text("\"k\" :\"wxyz\"");
      configure("k", 1, "", 0, 0, 9'd0);
      send_text("\"k\":\"q\"");

      configure("name", 4, "c{g", 3, 0, 9'd256);
      send_text("{\"name\":\"a\",\"c{g\" : {\"q\":\"\\\"name\\\":\",\"name\":\"v\"}}");
      send_text("{\"c{g\":{\"x\":{\"y\":2}}} \"name\":\"late\"");
      configure("abcdefghijklmnopq", 31, "ABCDEFGHIJKLMNOPQR", 20, 1, 9'd256);
      send_text("\"ABCDEFGHIJKLMNOP\"\n{\"abcdefghijklmnop\":7}");
      drain();

      for (int p = 0; p < 12; p++) begin
         case ($urandom_range(5))
            0: klen = 0;
            1: klen = 16;
            2: klen = $urandom_range(17, 31);
            default: klen = $urandom_range(1, 6);
         endcase
         slen = ($urandom_range(1)) ? 0 : (($urandom_range(4) == 0) ? 16 : $urandom_range(1, 5));
         cap = caps[p % 8];
         if (p == 5) cap = 9'd256;
         configure(rand_name(klen), klen, rand_name(slen), slen, p[0] ^ p[2], cap);
         set_mode(p);
         if (p == 5) -> begin_hold;
         bytes = 0;
         while (bytes < 50) begin
            build_doc();
            bytes += doc.size();
            send_doc();
         end
         drain();
      end

      set_mode(0);
      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("json_key_value_extractor_unit_tb passed");
      else $display("json_key_value_extractor_unit_tb failed");
      $finish;
   end

endmodule
`default_nettype wire
